### hw/rtl/clsp_pkg.sv
// ----------------------------------------------------------------------------
// clsp_pkg: shared definitions for the combined LCG shuffle generator
// Generator constants, controller states, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package clsp_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 32;
	localparam int unsigned WARMUP_STEPS_DEF  = 8;

	localparam logic [30:0] MOD_A         = 31'd2147483563;
	localparam logic [30:0] MOD_B         = 31'd2147483399;
	localparam logic [15:0] MUL_A         = 16'd40014;
	localparam logic [15:0] MUL_B         = 16'd40692;
	localparam logic [7:0]  GAP_A         = 8'd85;
	localparam logic [7:0]  GAP_B         = 8'd249;
	localparam logic [30:0] RANGE_TOP     = 31'd2147483562;
	localparam logic [31:0] FRACTION_CEIL = 32'd4294966780;
	localparam logic [30:0] RESET_SEED    = 31'd36;
	localparam logic [7:0]  FRAC_MUL      = 8'd170;

	typedef enum logic [3:0] {
		ST_SEED,
		ST_SMUL,
		ST_SRED,
		ST_IDLE,
		ST_MUL,
		ST_RED,
		ST_DIV,
		ST_READ,
		ST_UPD,
		ST_FRAC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic boot_seed;
		logic seed_load;
		logic seed_mul;
		logic seed_red;
		logic draw_mul;
		logic draw_red;
		logic mem_rd;
		logic upd;
		logic frac;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic seed_last;
		logic div_done;
		logic out_free;
	} status_t;

	// Reduces a 47-bit product modulo 2^31 - gap, where hi * gap stays small.
	function automatic logic [30:0] mod_reduce(input logic [46:0] prod,
		input logic [7:0] gap, input logic [30:0] modulus);
		logic [31:0] t;
		t = 32'(prod[46:31]) * 32'(gap) + 32'(prod[30:0]);
		if (t >= {1'b0, modulus}) begin
			t = t - {1'b0, modulus};
		end
		return t[30:0];
	endfunction

endpackage

### hw/rtl/clsp_slot_div.sv
// ----------------------------------------------------------------------------
// clsp_slot_div: shuffle slot selection
// Compares the last output against the slot boundaries, which are multiples of
// the slot divisor, and registers the slot on start. The highest boundary
// passed is the slot, so the result never exceeds the last table entry.
// ----------------------------------------------------------------------------
module clsp_slot_div #(
	parameter int unsigned TABLE_ENTRIES = clsp_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [30:0]                      dividend,
	output logic                             done,
	output logic [$clog2(TABLE_ENTRIES)-1:0] slot
);
	import clsp_pkg::*;

	localparam int unsigned   IDX_W        = $clog2(TABLE_ENTRIES);
	localparam logic [31:0]   SLOT_DIVISOR = 32'(1 + RANGE_TOP / TABLE_ENTRIES);

	logic [IDX_W-1:0] slot_d;
	logic [IDX_W-1:0] slot_q;
	logic             done_q;

	always_comb begin
		slot_d = '0;
		for (int k = 1; k < TABLE_ENTRIES; k++) begin
			if ({1'b0, dividend} >= 32'(k) * SLOT_DIVISOR) begin
				slot_d = IDX_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b1;
		end else begin
			done_q <= !start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			slot_q <= slot_d;
		end
	end

	assign done = done_q;
	assign slot = slot_q;

endmodule

### hw/rtl/clsp_datapath.sv
// ----------------------------------------------------------------------------
// clsp_datapath: generator datapath
// Both Lehmer generators, the shuffle table memory, the seeding counter, the
// slot divider, the fraction scaling and the output register.
// ----------------------------------------------------------------------------
module clsp_datapath #(
	parameter int unsigned TABLE_ENTRIES = clsp_pkg::TABLE_ENTRIES_DEF,
	parameter int unsigned WARMUP_STEPS  = clsp_pkg::WARMUP_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  clsp_pkg::cmd_t    cmd,
	output clsp_pkg::status_t status,
	input  logic [30:0]       seed_in,
	input  logic              m_ready,
	output logic              m_valid,
	output logic [30:0]       m_raw,
	output logic [31:0]       m_frac
);
	import clsp_pkg::*;

	localparam int unsigned IDX_W     = $clog2(TABLE_ENTRIES);
	localparam int unsigned SEQ_STEPS = TABLE_ENTRIES + WARMUP_STEPS;
	localparam int unsigned NW        = $clog2(SEQ_STEPS);

	logic [30:0]      seed_q;
	logic [30:0]      seed_src;
	logic [30:0]      seed_eff;
	logic [30:0]      g1_q;
	logic [30:0]      g2_q;
	logic [46:0]      p1_s1;
	logic [46:0]      p2_s1;
	logic [30:0]      g1_next;
	logic [30:0]      g2_next;
	logic [30:0]      last_q;
	logic [NW-1:0]    n_q;
	logic             n_in_table;
	logic [30:0]      tbl [0:TABLE_ENTRIES-1];
	logic             tbl_we;
	logic [IDX_W-1:0] tbl_wa;
	logic [30:0]      tbl_wd;
	logic [30:0]      rd_q;
	logic [IDX_W-1:0] slot;
	logic             div_done;
	logic [31:0]      d32;
	logic [30:0]      diff;
	logic [30:0]      raw_q;
	logic [38:0]      u_q;
	logic [31:0]      v;
	logic [8:0]       corr;
	logic [32:0]      frac33;
	logic [31:0]      frac_sat;
	logic             out_valid_q;
	logic [30:0]      out_raw_q;
	logic [31:0]      out_frac_q;

	clsp_slot_div #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.draw_mul),
		.dividend(last_q),
		.done    (div_done),
		.slot    (slot)
	);

	assign seed_src   = cmd.boot_seed ? RESET_SEED : seed_q;
	assign seed_eff   = (seed_src == '0) ? 31'd1 : seed_src;
	assign g1_next    = mod_reduce(p1_s1, GAP_A, MOD_A);
	assign g2_next    = mod_reduce(p2_s1, GAP_B, MOD_B);
	assign n_in_table = ({1'b0, n_q} < (NW + 1)'(TABLE_ENTRIES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (cmd.seed_load) begin
			n_q <= NW'(SEQ_STEPS - 1);
		end else if (cmd.seed_red && (n_q != '0)) begin
			n_q <= n_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			seed_q <= seed_in;
		end
		if (cmd.seed_load) begin
			g1_q <= seed_eff;
			g2_q <= seed_eff;
		end else begin
			if (cmd.seed_red || cmd.draw_red) begin
				g1_q <= g1_next;
			end
			if (cmd.draw_red) begin
				g2_q <= g2_next;
			end
		end
		if (cmd.seed_mul || cmd.draw_mul) begin
			p1_s1 <= 47'(g1_q) * 47'(MUL_A);
		end
		if (cmd.draw_mul) begin
			p2_s1 <= 47'(g2_q) * 47'(MUL_B);
		end
		if (cmd.seed_red && (n_q == '0)) begin
			last_q <= g1_next;
		end else if (cmd.upd) begin
			last_q <= diff;
		end
		if (cmd.upd) begin
			raw_q <= diff;
		end
		if (cmd.frac) begin
			u_q <= 39'(raw_q) * 39'(FRAC_MUL);
		end
		if (cmd.out_load) begin
			out_raw_q  <= raw_q;
			out_frac_q <= frac_sat;
		end
	end

	assign tbl_we = (cmd.seed_red && n_in_table) || cmd.upd;
	assign tbl_wa = cmd.upd ? slot : n_q[IDX_W-1:0];
	assign tbl_wd = cmd.upd ? g1_q : g1_next;

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl[tbl_wa] <= tbl_wd;
		end
		if (cmd.mem_rd) begin
			rd_q <= tbl[slot];
		end
	end

	// The entry minus the second generator, wrapped into 1 .. RANGE_TOP.
	assign d32  = {1'b0, rd_q} + ((rd_q > g2_q) ? 32'd0 : {1'b0, RANGE_TOP})
	              - {1'b0, g2_q};
	assign diff = d32[30:0];

	// floor(raw * 2^32 / MOD_A) = 2 * raw + floor(170 * raw / MOD_A).
	assign v        = 32'(u_q[38:31]) * 32'(GAP_A) + 32'(u_q[30:0]);
	assign corr     = 9'(u_q[38:31]) + 9'(v >= {1'b0, MOD_A});
	assign frac33   = {1'b0, raw_q, 1'b0} + 33'(corr);
	assign frac_sat = (frac33 > 33'(FRACTION_CEIL)) ? FRACTION_CEIL : frac33[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.seed_last = (n_q == '0);
	assign status.div_done  = div_done;
	assign status.out_free  = !out_valid_q || m_ready;

	assign m_valid = out_valid_q;
	assign m_raw   = out_raw_q;
	assign m_frac  = out_frac_q;

endmodule

### hw/rtl/clsp_ctrl.sv
// ----------------------------------------------------------------------------
// clsp_ctrl: sequencing controller
// Steps the datapath through seeding and drawing and owns the input request
// handshake.
// ----------------------------------------------------------------------------
module clsp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_valid,
	input  logic              req_type,
	input  clsp_pkg::status_t status,
	output logic              s_ready,
	output clsp_pkg::cmd_t    cmd
);
	import clsp_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   boot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SEED;
			boot_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_SRED) && status.seed_last) begin
				boot_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_SEED: state_d = ST_SMUL;
			ST_SMUL: state_d = ST_SRED;
			ST_SRED: begin
				if (status.seed_last) begin
					state_d = boot_q ? ST_IDLE : ST_MUL;
				end else begin
					state_d = ST_SMUL;
				end
			end
			ST_IDLE: begin
				if (s_valid) begin
					state_d = req_type ? ST_SEED : ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_RED;
			ST_RED:  state_d = ST_DIV;
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_UPD;
			ST_UPD:  state_d = ST_FRAC;
			ST_FRAC: state_d = ST_OUT;
			ST_OUT: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd     = '0;
		s_ready = 1'b0;
		case (state_q)
			ST_SEED: begin
				cmd.seed_load = 1'b1;
				cmd.boot_seed = boot_q;
			end
			ST_SMUL: cmd.seed_mul = 1'b1;
			ST_SRED: cmd.seed_red = 1'b1;
			ST_IDLE: begin
				s_ready     = 1'b1;
				cmd.capture = s_valid;
			end
			ST_MUL:  cmd.draw_mul = 1'b1;
			ST_RED:  cmd.draw_red = 1'b1;
			ST_READ: cmd.mem_rd   = 1'b1;
			ST_UPD:  cmd.upd      = 1'b1;
			ST_FRAC: cmd.frac     = 1'b1;
			ST_OUT:  cmd.out_load = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

### hw/rtl/combined_lcg_shuffle_prng.sv
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_prng: combined LCG generator with shuffle table
// Each request on the slave stream yields one uniform number on the master
// stream. tuser selects a plain draw (0) or a reseed followed by a draw (1);
// on reseed the seed in tdata replaces the state, a zero seed acting as one.
// Results carry the raw integer and a saturated Q0.32 fraction.
// One request is handled at a time. A draw steps through generator multiply,
// modular reduce, slot select, table read, table update, fraction scaling and
// output load before its result is valid; a new request is accepted only once
// the previous one has reached the output register.
// A reseed adds the seeding sequence, in which the first generator is stepped
// through its multiply and reduce states once per step, for TABLE_ENTRIES +
// WARMUP_STEPS steps.
// After reset the block seeds itself with 36 in the same way; s_tready stays
// low until that completes and no result is made.
// The result sits in an output register, so the next request is accepted
// while it waits; if the receiver still stalls when the following result is
// ready, the block holds that result and accepts nothing until it drains.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_prng #(
	parameter int unsigned TABLE_ENTRIES = clsp_pkg::TABLE_ENTRIES_DEF,
	parameter int unsigned WARMUP_STEPS  = clsp_pkg::WARMUP_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [30:0] seed_magnitude
	input  logic        s_tuser,  // [0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata   // [30:0] raw_value, [62:31] fraction
);
	import clsp_pkg::*;

	cmd_t        cmd;
	status_t     status;
	logic [30:0] raw;
	logic [31:0] frac;

	clsp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.req_type(s_tuser),
		.status  (status),
		.s_ready (s_tready),
		.cmd     (cmd)
	);

	clsp_datapath #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.WARMUP_STEPS (WARMUP_STEPS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status),
		.seed_in(s_tdata[30:0]),
		.m_ready(m_tready),
		.m_valid(m_tvalid),
		.m_raw  (raw),
		.m_frac (frac)
	);

	assign m_tdata = {1'b0, frac, raw};

endmodule

### hw/rtl/clsp_checker.sv
// ----------------------------------------------------------------------------
// clsp_checker: port checks for the combined LCG shuffle generator
// Watches the stream ports for output stability, result ranges and the
// one-request-at-a-time acceptance.
// ----------------------------------------------------------------------------
module clsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);
	import clsp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Stalled result was dropped.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("Stalled result changed.");

	a_raw_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[30:0] != 31'd0) && (m_tdata[30:0] <= RANGE_TOP))
		else $error("Raw value out of range.");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[62:31] <= FRACTION_CEIL) && !m_tdata[63])
		else $error("Fraction above its ceiling.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Request accepted while another is in progress.");

endmodule

bind combined_lcg_shuffle_prng clsp_checker u_clsp_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the combined LCG shuffle generator
// A queue of draw and reseed requests feeds a stream driver. Each accepted
// request steps a local model of both generators and the shuffle table, and
// the expected number is queued. A monitor compares every result, field by
// field, with the oldest expected one. Both sides idle at random, except
// during a stretch in the middle of the run.
// ----------------------------------------------------------------------------
module tb;
	import clsp_pkg::*;

	localparam int unsigned SLOTS       = TABLE_ENTRIES_DEF;
	localparam int unsigned WARMUP      = WARMUP_STEPS_DEF;
	localparam int unsigned SLOT_WIDTH  = 32'd1 + 32'(RANGE_TOP) / SLOTS;
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned RANDOM_REQS = 800;
	localparam int unsigned CALM_FROM   = 300;
	localparam int unsigned CALM_TO     = 450;

	typedef enum logic {
		REQ_DRAW   = 1'b0,
		REQ_RESEED = 1'b1
	} req_kind_t;

	typedef struct {
		req_kind_t   kind;
		logic [30:0] seed;
	} request_t;

	typedef struct {
		logic [30:0] raw;
		logic [31:0] frac;
	} draw_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;  // [30:0] seed_magnitude
	logic        s_tuser  = 1'b0;  // [0] req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;  // [30:0] raw_value, [62:31] fraction

	request_t    request_q[$];
	draw_t       expected_draws[$];
	int unsigned total_requests = 0;
	int unsigned accepted_requests = 0;
	int unsigned received_draws = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;

	logic [30:0] gen_a;
	logic [30:0] gen_b;
	logic [30:0] prev_out;
	logic [30:0] shuffle [SLOTS];

	combined_lcg_shuffle_prng dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	function automatic logic [30:0] lehmer(input logic [30:0] x, input logic [15:0] mul,
		input logic [30:0] modulus);
		longint unsigned p;
		p = (64'(x) * 64'(mul)) % 64'(modulus);
		return p[30:0];
	endfunction

	function void reseed_model(input logic [30:0] seed);
		logic [30:0] s;
		s = (seed == '0) ? 31'd1 : seed;
		gen_a = s;
		gen_b = s;
		for (int n = SLOTS + WARMUP - 1; n >= 0; n--) begin
			gen_a = lehmer(gen_a, MUL_A, MOD_A);
			if (n < SLOTS) begin
				shuffle[n] = gen_a;
			end
		end
		prev_out = shuffle[0];
	endfunction

	function draw_t next_draw();
		int unsigned     slot;
		longint          diff;
		longint unsigned q;
		draw_t           d;
		gen_a = lehmer(gen_a, MUL_A, MOD_A);
		gen_b = lehmer(gen_b, MUL_B, MOD_B);
		slot = 32'(prev_out) / SLOT_WIDTH;
		if (slot >= SLOTS) begin
			slot = SLOTS - 1;
		end
		diff = longint'(64'(shuffle[slot])) - longint'(64'(gen_b));
		shuffle[slot] = gen_a;
		if (diff < 1) begin
			diff = diff + longint'(64'(RANGE_TOP));
		end
		prev_out = diff[30:0];
		q = (64'(prev_out) << 32) / 64'(MOD_A);
		if (q > 64'(FRACTION_CEIL)) begin
			q = 64'(FRACTION_CEIL);
		end
		d.raw  = prev_out;
		d.frac = q[31:0];
		return d;
	endfunction

	function automatic void add_request(input req_kind_t kind, input logic [30:0] seed);
		request_t r;
		r.kind = kind;
		r.seed = seed;
		request_q.push_back(r);
		total_requests++;
	endfunction

	function automatic logic [30:0] pick_seed();
		logic [30:0] s;
		case ($urandom_range(0, 9))
			0, 1: begin
				s = 31'($urandom_range(0, 100));
			end
			2: begin
				s = MOD_B - 31'd2 + 31'($urandom_range(0, 4));
			end
			3: begin
				s = RANGE_TOP - 31'd1 + 31'($urandom_range(0, 85));
			end
			default: begin
				s = 31'($urandom());
			end
		endcase
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (s_tuser == REQ_RESEED) begin
					reseed_model(s_tdata[30:0]);
				end
				expected_draws.push_back(next_draw());
				accepted_requests++;
			end
			if (!s_tvalid || s_tready) begin
				if (request_q.size() != 0 && ((accepted_requests >= CALM_FROM &&
					accepted_requests < CALM_TO) || $urandom_range(0, 99) >= 28)) begin
					s_tvalid <= 1'b1;
					s_tuser  <= request_q[0].kind;
					s_tdata  <= {1'b0, request_q[0].seed};
					request_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				received_draws++;
				if (expected_draws.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual raw %0d frac %0d",
						$time, m_tdata[30:0], m_tdata[62:31]);
					mismatches++;
				end else begin
					if (m_tdata[30:0] !== expected_draws[0].raw) begin
						$display("%0t: raw_value mismatch, expected %0d, actual %0d",
							$time, expected_draws[0].raw, m_tdata[30:0]);
						mismatches++;
					end
					if (m_tdata[62:31] !== expected_draws[0].frac) begin
						$display("%0t: fraction mismatch, expected %0d, actual %0d",
							$time, expected_draws[0].frac, m_tdata[62:31]);
						mismatches++;
					end
					expected_draws.pop_front();
				end
			end
			m_tready <= (received_draws >= CALM_FROM && received_draws < CALM_TO) ||
				$urandom_range(0, 99) >= 28;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		reseed_model(RESET_SEED);

		add_request(REQ_DRAW, '0);
		add_request(REQ_DRAW, '1);
		add_request(REQ_RESEED, 31'd0);
		add_request(REQ_DRAW, '0);
		add_request(REQ_RESEED, 31'd1);
		add_request(REQ_DRAW, 31'h2AAA_AAAA);
		add_request(REQ_RESEED, RANGE_TOP);
		add_request(REQ_DRAW, '0);
		add_request(REQ_RESEED, MOD_A);
		add_request(REQ_DRAW, '0);
		add_request(REQ_DRAW, '0);
		add_request(REQ_RESEED, MOD_B);
		add_request(REQ_DRAW, '0);
		add_request(REQ_DRAW, '0);
		add_request(REQ_RESEED, 31'h7FFF_FFFF);
		add_request(REQ_DRAW, '1);
		add_request(REQ_RESEED, RESET_SEED);
		add_request(REQ_DRAW, '0);
		add_request(REQ_RESEED, 31'h5555_5555);
		add_request(REQ_DRAW, '0);

		for (int i = 0; i < RANDOM_REQS; i++) begin
			if ($urandom_range(0, 99) < 5) begin
				add_request(REQ_RESEED, pick_seed());
			end else begin
				add_request(REQ_DRAW, 31'($urandom()));
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_requests != total_requests) begin
			@(posedge clk);
		end
		while (expected_draws.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);

		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/clsp_pkg.sv
hw/rtl/clsp_slot_div.sv
hw/rtl/clsp_datapath.sv
hw/rtl/clsp_ctrl.sv
hw/rtl/combined_lcg_shuffle_prng.sv
hw/rtl/clsp_checker.sv
tb/tb.sv
